[src/assert_macros.svh]
// assertion macros used by the top-level rtl file of the time step selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle check");

`endif

[src/atss_pkg.sv]
// package with types, constants and register codes of the time step selector
`timescale 1ns / 1ps
`default_nettype none

package atss_pkg;

    localparam int DIST_W = 24;
    localparam int RATE_W = 16;
    localparam int STEP_W = 16;
    localparam int THR_W  = 24;
    localparam int NUM_W  = DIST_W + STEP_W;
    localparam int QUOT_W = STEP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FLOOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THRESHOLD = 3'd4;

    localparam logic              RST_DYNAMIC_ENABLE  = 1'b1;
    localparam logic [STEP_W-1:0] RST_COARSE_STEP     = 16'd960;
    localparam logic [STEP_W-1:0] RST_STEP_FLOOR      = 16'd16;
    localparam logic [STEP_W-1:0] RST_MAX_STEP        = 16'd960;
    localparam logic [THR_W-1:0]  RST_CLOSE_THRESHOLD = 24'd2560;

    // 0.01 km/s in 1/1024 km/s, first rate strictly above it
    localparam logic signed [RATE_W-1:0] FAST_RATE = 16'sd11;

    typedef enum logic [1:0] {
        BR_COARSE  = 2'd0,
        BR_MAX     = 2'd1,
        BR_CLOSING = 2'd2,
        BR_INTERP  = 2'd3
    } atss_branch_t;

    typedef struct packed {
        logic              dynamic_enable;
        logic [STEP_W-1:0] coarse_step;
        logic [STEP_W-1:0] step_floor;
        logic [STEP_W-1:0] max_step;
        logic [THR_W-1:0]  close_threshold;
    } atss_cfg_t;

    typedef struct packed {
        atss_branch_t branch;
        logic         full;
        logic         sat;
    } atss_side_t;

    typedef struct packed {
        logic [THR_W-1:0]  rem;
        logic [QUOT_W-1:0] nq;
        logic [THR_W-1:0]  divisor;
        atss_side_t        side;
    } atss_div_t;

endpackage

`default_nettype wire

[src/atss_in_if.sv]
// request channel carrying distance and closing rate
`timescale 1ns / 1ps
`default_nettype none

interface atss_in_if
    import atss_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [DIST_W-1:0]        distance;
    logic signed [RATE_W-1:0] approach_rate;

    modport source (output valid, output distance, output approach_rate, input ready);
    modport sink (input valid, input distance, input approach_rate, output ready);
endinterface

`default_nettype wire

[src/atss_out_if.sv]
// result channel carrying the chosen step and branch code
`timescale 1ns / 1ps
`default_nettype none

interface atss_out_if
    import atss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_size;
    logic [1:0]        branch_taken;

    modport source (output valid, output step_size, output branch_taken, input ready);
    modport sink (input valid, input step_size, input branch_taken, output ready);
endinterface

`default_nettype wire

[src/atss_front.sv]
// decode stage: branch choice, dividend and divisor set-up
`timescale 1ns / 1ps
`default_nettype none

module atss_front
    import atss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire atss_cfg_t cfg,
    atss_in_if.sink        query,
    output logic           next_valid,
    input  wire logic      next_ready,
    output atss_div_t      next_data
);

    logic                     valid_reg;
    atss_div_t                data_reg;
    atss_div_t                data_next;
    logic [DIST_W-1:0]        d;
    logic signed [RATE_W-1:0] r;
    logic [THR_W-1:0]         t;
    logic [17:0]              five_r;
    logic [STEP_W-1:0]        diff;
    logic [NUM_W-1:0]         prod;
    logic [NUM_W-1:0]         num;
    logic                     far;
    logic                     not_closing;
    atss_branch_t             branch;

    assign query.ready = !valid_reg || next_ready;

    always_comb
    begin
        d = query.distance;
        r = query.approach_rate;
        t = cfg.close_threshold;
        five_r = {2'b00, r[15:0]} + {r[15:0], 2'b00};
        diff = (cfg.max_step >= cfg.step_floor) ? cfg.max_step - cfg.step_floor
                                                : cfg.step_floor - cfg.max_step;
        prod = NUM_W'(d) * NUM_W'(diff);
        far = {1'b0, d} > {t, 1'b0};
        not_closing = r[RATE_W-1] || (r == '0);
        priority if (!cfg.dynamic_enable)
            branch = BR_COARSE;
        else if (far || not_closing)
            branch = BR_MAX;
        else if ((r >= FAST_RATE) && (d < t))
            branch = BR_CLOSING;
        else
            branch = BR_INTERP;
        num = (branch == BR_CLOSING) ? {11'b0, d, 5'b0} : prod;
        data_next.rem = num[NUM_W-1:QUOT_W];
        data_next.nq = num[QUOT_W-1:0];
        data_next.divisor = (branch == BR_CLOSING) ? {6'b0, five_r} : t;
        data_next.side.branch = branch;
        data_next.side.full = (t == '0) || (d >= t);
        // quotient would need more than 16 bits
        data_next.side.sat = (branch == BR_CLOSING) && ({5'b0, d[23:11]} >= five_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (query.ready)
        begin
            valid_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query.ready && query.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign next_valid = valid_reg;
    assign next_data = data_reg;

endmodule

`default_nettype wire

[src/atss_div_cell.sv]
// one restoring-division cell, one quotient bit per cell
`timescale 1ns / 1ps
`default_nettype none

module atss_div_cell
    import atss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      prev_valid,
    output logic           prev_ready,
    input  wire atss_div_t prev_data,
    output logic           next_valid,
    input  wire logic      next_ready,
    output atss_div_t      next_data
);

    logic             valid_reg;
    atss_div_t        data_reg;
    atss_div_t        data_next;
    logic [THR_W:0]   trial;
    logic [THR_W:0]   delta;
    logic             ge;

    assign prev_ready = !valid_reg || next_ready;

    always_comb
    begin
        trial = {prev_data.rem, prev_data.nq[QUOT_W-1]};
        delta = trial - {1'b0, prev_data.divisor};
        ge = trial >= {1'b0, prev_data.divisor};
        data_next = prev_data;
        data_next.rem = ge ? delta[THR_W-1:0] : trial[THR_W-1:0];
        data_next.nq = {prev_data.nq[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (prev_ready)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_ready && prev_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign next_valid = valid_reg;
    assign next_data = data_reg;

endmodule

`default_nettype wire

[src/atss_back.sv]
// result stage: clamp, interpolation offset and output register
`timescale 1ns / 1ps
`default_nettype none

module atss_back
    import atss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire atss_cfg_t cfg,
    input  wire logic      prev_valid,
    output logic           prev_ready,
    input  wire atss_div_t prev_data,
    atss_out_if.source     reply
);

    logic              valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    atss_branch_t      branch_reg;
    logic [STEP_W-1:0] raw;
    logic [STEP_W-1:0] capped;
    logic [STEP_W-1:0] clamped;
    logic [STEP_W-1:0] interp;
    logic              rem_nz;

    assign prev_ready = !valid_reg || reply.ready;

    always_comb
    begin
        raw = prev_data.side.sat ? '1 : prev_data.nq;
        capped = (raw > cfg.max_step) ? cfg.max_step : raw;
        clamped = (capped < cfg.step_floor) ? cfg.step_floor : capped;
        rem_nz = prev_data.rem != '0;
        // reversed limits round the downward offset up
        if (prev_data.side.full)
            interp = cfg.max_step;
        else if (cfg.max_step >= cfg.step_floor)
            interp = cfg.step_floor + prev_data.nq;
        else
            interp = cfg.step_floor - prev_data.nq - STEP_W'(rem_nz);
        unique case (prev_data.side.branch)
            BR_COARSE:  step_next = cfg.coarse_step;
            BR_MAX:     step_next = cfg.max_step;
            BR_CLOSING: step_next = clamped;
            BR_INTERP:  step_next = interp;
            default:    step_next = cfg.max_step;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (prev_ready)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_ready && prev_valid)
        begin
            step_reg <= step_next;
            branch_reg <= prev_data.side.branch;
        end
    end

    assign reply.valid = valid_reg;
    assign reply.step_size = step_reg;
    assign reply.branch_taken = branch_reg;

endmodule

`default_nettype wire

[src/adaptive_time_step_select_core.sv]
// top level of the adaptive time step selector
// One result per request, one request per cycle sustained while results are taken. The
// pipeline holds a decode stage (branch choice, 24x16 dividend product), a row of 16
// division cells that each settle one quotient bit, and the output register.
// Every stage holds its own valid bit and takes a new request whenever it is empty
// or its successor moves, so bubbles close up and requests keep entering while a
// result waits at the output. Configuration registers are read live by the decode
// and output stages and are meant to be written while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adaptive_time_step_select_core
    import atss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    atss_in_if.sink                    query,
    atss_out_if.source                 reply
);

    atss_cfg_t cfg_reg;
    logic      stage_valid [0:QUOT_W];
    logic      stage_ready [0:QUOT_W];
    atss_div_t stage_data  [0:QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dynamic_enable <= RST_DYNAMIC_ENABLE;
            cfg_reg.coarse_step <= RST_COARSE_STEP;
            cfg_reg.step_floor <= RST_STEP_FLOOR;
            cfg_reg.max_step <= RST_MAX_STEP;
            cfg_reg.close_threshold <= RST_CLOSE_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DYNAMIC_ENABLE:  cfg_reg.dynamic_enable <= cfg_wdata[0];
                CFG_COARSE_STEP:     cfg_reg.coarse_step <= cfg_wdata[STEP_W-1:0];
                CFG_STEP_FLOOR:      cfg_reg.step_floor <= cfg_wdata[STEP_W-1:0];
                CFG_MAX_STEP:        cfg_reg.max_step <= cfg_wdata[STEP_W-1:0];
                CFG_CLOSE_THRESHOLD: cfg_reg.close_threshold <= cfg_wdata[THR_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    atss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .query      (query),
        .next_valid (stage_valid[0]),
        .next_ready (stage_ready[0]),
        .next_data  (stage_data[0])
    );

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_cell
        atss_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_valid (stage_valid[i]),
            .prev_ready (stage_ready[i]),
            .prev_data  (stage_data[i]),
            .next_valid (stage_valid[i+1]),
            .next_ready (stage_ready[i+1]),
            .next_data  (stage_data[i+1])
        );
    end

    atss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .prev_valid (stage_valid[QUOT_W]),
        .prev_ready (stage_ready[QUOT_W]),
        .prev_data  (stage_data[QUOT_W]),
        .reply      (reply)
    );

    `ASSERT_NEXT(a_front_capture, query.valid && query.ready, stage_valid[0])
    `ASSERT_NOW(a_coarse_only_when_off, reply.valid,
        (reply.branch_taken == BR_COARSE) == !cfg_reg.dynamic_enable)
    `ASSERT_NOW(a_closing_floor, reply.valid && (reply.branch_taken == BR_CLOSING),
        reply.step_size >= cfg_reg.step_floor)
    `ASSERT_NOW(a_interp_bounds, reply.valid && (reply.branch_taken == BR_INTERP)
        && (cfg_reg.max_step >= cfg_reg.step_floor),
        (reply.step_size >= cfg_reg.step_floor) && (reply.step_size <= cfg_reg.max_step))

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for the adaptive time step selector
`timescale 1ns / 1ps

module tb
    import atss_pkg::*;
();

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } pacing_t;

    typedef struct {
        logic [DIST_W-1:0]        sep;
        logic signed [RATE_W-1:0] rate;
        logic [STEP_W-1:0]        step;
        atss_branch_t             branch;
    } step_pick_t;

    class step_choice_board;
        atss_cfg_t  regs;
        step_pick_t pending_picks[$];
        int         faults;

        function new();
            regs.dynamic_enable  = RST_DYNAMIC_ENABLE;
            regs.coarse_step     = RST_COARSE_STEP;
            regs.step_floor      = RST_STEP_FLOOR;
            regs.max_step        = RST_MAX_STEP;
            regs.close_threshold = RST_CLOSE_THRESHOLD;
            faults = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DYNAMIC_ENABLE:  regs.dynamic_enable  = data[0];
                CFG_COARSE_STEP:     regs.coarse_step     = data[STEP_W-1:0];
                CFG_STEP_FLOOR:      regs.step_floor      = data[STEP_W-1:0];
                CFG_MAX_STEP:        regs.max_step        = data[STEP_W-1:0];
                CFG_CLOSE_THRESHOLD: regs.close_threshold = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function step_pick_t pick_step(logic [DIST_W-1:0] sep, logic signed [RATE_W-1:0] rate);
            step_pick_t     p;
            longint unsigned d;
            longint unsigned t;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned rv;
            longint unsigned raw;
            d  = sep;
            t  = regs.close_threshold;
            lo = regs.step_floor;
            hi = regs.max_step;
            p.sep  = sep;
            p.rate = rate;
            if (!regs.dynamic_enable)
            begin
                p.step   = regs.coarse_step;
                p.branch = BR_COARSE;
            end
            else if (d > 2 * t || rate <= 0)
            begin
                p.step   = regs.max_step;
                p.branch = BR_MAX;
            end
            else if (rate >= FAST_RATE && d < t)
            begin
                // time to contact over ten, in 1/16 s
                rv  = rate[RATE_W-2:0];
                raw = (d * 32) / (5 * rv);
                if (raw > 65535)
                    raw = 65535;
                if (raw > hi)
                    raw = hi;
                if (raw < lo)
                    raw = lo;
                p.step   = raw[STEP_W-1:0];
                p.branch = BR_CLOSING;
            end
            else
            begin
                if (t == 0 || d >= t)
                    raw = hi;
                else if (hi >= lo)
                    raw = lo + (d * (hi - lo)) / t;
                else
                    raw = lo - (d * (lo - hi) + t - 1) / t;
                p.step   = raw[STEP_W-1:0];
                p.branch = BR_INTERP;
            end
            return p;
        endfunction

        function void note_query(logic [DIST_W-1:0] sep, logic signed [RATE_W-1:0] rate);
            pending_picks = {pending_picks, pick_step(sep, rate)};
        endfunction

        function void check_reply(logic [STEP_W-1:0] step, logic [1:0] branch);
            step_pick_t p;
            if (pending_picks.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("reply with no request pending: step %0d branch %0d", step, branch);
                return;
            end
            p = pending_picks.pop_front();
            if (p.step !== step || p.branch !== branch)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $write("mismatch distance %0d rate %0d: ", p.sep, p.rate);
                    $display("expected step %0d branch %0d, got step %0d branch %0d",
                             p.step, p.branch, step, branch);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    pacing_t               pacing;
    bit                    hold_replies;
    int                    quiet_cycles;
    step_choice_board      sb;

    atss_in_if  query ();
    atss_out_if reply ();

    adaptive_time_step_select_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .query     (query),
        .reply     (reply)
    );

    always #1 clk = ~clk;

    // receiver pacing, with one long hold-off on request
    initial
    begin
        reply.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_replies)
            begin
                reply.ready = 1'b0;
                repeat (80) @(negedge clk);
                hold_replies = 1'b0;
            end
            else
            begin
                case (pacing)
                    IDLE_RX_HEAVY: reply.ready = ($urandom_range(0, 99) >= 81);
                    IDLE_TX_HEAVY: reply.ready = ($urandom_range(0, 99) >= 10);
                    default:       reply.ready = 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && reply.valid && reply.ready)
            sb.check_reply(reply.step_size, reply.branch_taken);
    end

    always @(posedge clk)
    begin
        if ((query.valid && query.ready) || (reply.valid && reply.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 5000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    // junk in the unused upper bits must be dropped
    task automatic set_config(input logic en, input logic [STEP_W-1:0] coarse,
                              input logic [STEP_W-1:0] lo, input logic [STEP_W-1:0] hi,
                              input logic [THR_W-1:0] thr);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_CLOSE_THRESHOLD + 3'($urandom_range(1, 3));
        write_reg(CFG_DYNAMIC_ENABLE, {23'($urandom), en});
        write_reg(CFG_COARSE_STEP, {8'($urandom), coarse});
        write_reg(CFG_STEP_FLOOR, {8'($urandom), lo});
        write_reg(CFG_MAX_STEP, {8'($urandom), hi});
        write_reg(CFG_CLOSE_THRESHOLD, thr);
        write_reg(spare, 24'($urandom));
        cfg_we = 1'b0;
    endtask

    task automatic send_query(input logic [DIST_W-1:0] sep, input logic signed [RATE_W-1:0] rate);
        int gap;
        case (pacing)
            IDLE_RX_HEAVY: gap = 10;
            IDLE_TX_HEAVY: gap = 81;
            default:       gap = 0;
        endcase
        while ($urandom_range(0, 99) < gap)
        begin
            query.valid = 1'b0;
            @(negedge clk);
        end
        query.valid         = 1'b1;
        query.distance      = sep;
        query.approach_rate = rate;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        sb.note_query(sep, rate);
        @(negedge clk);
    endtask

    task automatic drain();
        query.valid = 1'b0;
        while (sb.pending_picks.size() != 0)
            @(negedge clk);
    endtask

    // distances cluster around the threshold, rates around the fast limit
    task automatic send_random(input int n, input int stall_at);
        longint unsigned t;
        longint unsigned d;
        logic signed [RATE_W-1:0] r;
        for (int i = 0; i < n; i++)
        begin
            t = sb.regs.close_threshold;
            case ($urandom_range(0, 5))
                0, 1: d = $urandom_range(0, t);
                2: d = t + $urandom_range(0, t);
                3: d = $urandom & 24'hFFFFFF;
                4:
                begin
                    case ($urandom_range(0, 6))
                        0: d = 0;
                        1: d = t - 1;
                        2: d = t;
                        3: d = t + 1;
                        4: d = 2 * t;
                        5: d = 2 * t + 1;
                        default: d = 24'hFFFFFF;
                    endcase
                end
                default: d = $urandom_range(0, 255);
            endcase
            if (d > 24'hFFFFFF)
                d = 24'hFFFFFF;
            case ($urandom_range(0, 7))
                0: r = 16'($urandom);
                1: r = -16'sd1 * 16'($urandom_range(0, 32768));
                2: r = 16'($urandom_range(1, 10));
                3: r = 16'($urandom_range(11, 32767));
                default: r = 16'($urandom_range(11, 2000));
            endcase
            if (i == stall_at)
                hold_replies = 1'b1;
            send_query(d[DIST_W-1:0], r);
        end
        drain();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        query.valid  = 1'b0;
        query.distance      = '0;
        query.approach_rate = '0;
        pacing       = IDLE_RX_HEAVY;
        hold_replies = 1'b0;
        quiet_cycles = 0;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings
        send_query(24'd0, 16'sd0);
        send_query(24'd0, -16'sd32768);
        send_query(24'hFFFFFF, 16'sd32767);
        send_query(24'd5120, 16'sd100);
        send_query(24'd5121, 16'sd100);
        send_query(24'd2559, 16'sd11);
        send_query(24'd2559, 16'sd10);
        send_query(24'd100, 16'sd32767);
        send_query(24'd1000, 16'sd1);
        send_query(24'd2560, 16'sd11);
        send_query(24'd0, 16'sd11);
        send_query(24'd1280, 16'sd500);
        send_query(24'd2000, 16'sd200);
        drain();

        set_config(1'b1, 16'd960, 16'd16, 16'd960, 24'd2560);
        send_random(70, -1);

        // adaptive mode off
        set_config(1'b0, 16'hFFFF, 16'd16, 16'd960, 24'd2560);
        send_query(24'd100, 16'sd50);
        send_query(24'hFFFFFF, -16'sd1);
        send_random(40, -1);

        // widest limits, largest threshold, quotient saturates
        set_config(1'b1, 16'd0, 16'd0, 16'hFFFF, 24'hFFFFFF);
        send_query(24'd16777214, 16'sd11);
        send_query(24'd0, 16'sd32767);
        send_query(24'd8388607, 16'sd5);
        send_query(24'hFFFFFF, -16'sd1);
        send_query(24'hFFFFFF, 16'sd1);
        send_random(70, -1);

        // limits in reverse order
        pacing = IDLE_TX_HEAVY;
        set_config(1'b1, 16'd300, 16'd1000, 16'd100, 24'd2560);
        send_query(24'd2559, 16'sd11);
        send_query(24'd1280, 16'sd5);
        send_query(24'd0, 16'sd5);
        send_query(24'd0, -16'sd5);
        drain();
        send_random(70, -1);

        // zero threshold
        set_config(1'b1, 16'd960, 16'd16, 16'd960, 24'd0);
        send_query(24'd0, 16'sd1);
        send_query(24'd1, 16'sd20);
        send_random(40, -1);

        set_config(1'b1, 16'd1, 16'hFFFF, 16'hFFFF, 24'd1);
        send_random(40, -1);

        pacing = IDLE_NONE;
        repeat (3)
        begin
            set_config($urandom_range(0, 7) != 0, 16'($urandom), 16'($urandom_range(0, 2000)),
                       16'($urandom), 24'($urandom_range(0, (1 << $urandom_range(0, 24)) - 1)));
            send_random(60, 10);
        end

        set_config(1'b0, 16'd0, 16'd16, 16'd960, 24'd2560);
        send_random(20, -1);

        repeat (40) @(posedge clk);
        if (sb.faults == 0 && sb.pending_picks.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
